// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the console modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Stream payload widths (whole bytes).
   localparam int REQ_W = 32;
   localparam int RSP_W = 40;

   // Character codes.
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] BLANK_CODE   = 8'h20;

   // Reset values of the color registers.
   localparam logic [3:0] FG_RESET = 4'hF;
   localparam logic [3:0] BG_RESET = 4'h0;

   // Configuration register indexes.
   localparam logic CSR_DEFAULT_FG = 1'b0;
   localparam logic CSR_DEFAULT_BG = 1'b1;

   typedef enum logic [1:0] {
      ACT_PUT_CHAR   = 2'd0,
      ACT_WRITE_CELL = 2'd1,
      ACT_CLEAR      = 2'd2,
      ACT_READ_CELL  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_BLANK_ROW,
      ST_FILL
   } back_state_type;

   // Classified command passed from the front end to the executor.
   typedef struct packed {
      action_type  action;
      logic        is_newline;
      logic        bad_index;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
      logic [7:0]  attr;
      logic        last;
   } cmd_type;

   // Result layout, lowest bits first.
   function automatic logic [RSP_W-1:0] pack_rsp(
      input logic [10:0] cursor_pos,
      input logic [10:0] shown_cursor,
      input logic [7:0]  read_char,
      input logic [7:0]  read_attr,
      input logic        scrolled,
      input logic        bad_index
   );
      return {bad_index, scrolled, read_attr, read_char, shown_cursor, cursor_pos};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode character console with cursor, scrolling and cell access.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                          Contents
//  req       in         req_tvalid/tready/tdata/tuser  console command, tlast = end of call
//  rsp       out        rsp_tvalid/tready/tdata        cursors, cell read, status flags
//  csr       in         csr_we/csr_addr/csr_wdata      default foreground and background
//
//  Put char (when it does not scroll) and write cell finish in the idle state; an in-range
//  read cell adds a read state (registered memory read). A scroll copies every row up (one
//  copy per cycle through the single memory write port), then blanks the bottom row; clear
//  blanks every cell. After reset the memory is blanked with req_tready low.
//  A two-entry queue lets requests be taken while the executor works or the
//  result register waits on rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire                       clock,
   input  wire                       reset,
   // tdata: char_code[7:0], cell_index[18:8], fg_in[22:19], bg_in[26:23], zero[31:27]
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire [tcw_pkg::REQ_W-1:0]  req_tdata,
   // tuser: action[1:0]
   input  wire [1:0]                 req_tuser,
   input  wire                       req_tlast,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // tdata: cursor_pos[10:0], shown_cursor[21:11], read_char[29:22],
   //        read_attr[37:30], scrolled[38], bad_index[39]
   output logic [tcw_pkg::RSP_W-1:0] rsp_tdata,
   input  wire                       csr_we,
   input  wire                       csr_addr,
   input  wire [3:0]                 csr_wdata
);
   import tcw_pkg::*;

   logic [3:0] fg_ff, bg_ff;
   logic       init_busy;
   logic       f_valid, f_ready, q_valid, q_pop;
   cmd_type    f_data, q_data;

   // Color registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEFAULT_FG: fg_ff <= csr_wdata;
            CSR_DEFAULT_BG: bg_ff <= csr_wdata;
            default:        fg_ff <= fg_ff;
         endcase
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (init_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd_data   (f_data)
   );

   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_data)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_fg     (fg_ff),
      .cfg_bg     (bg_ff),
      .cmd_valid  (q_valid),
      .cmd_data   (q_data),
      .cmd_pop    (q_pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hdl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request transactions, decodes and range-checks them into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       hold,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire [tcw_pkg::REQ_W-1:0]  req_tdata,
   input  wire [1:0]                 req_tuser,
   input  wire                       req_tlast,
   output logic                      cmd_valid,
   input  wire                       cmd_ready,
   output tcw_pkg::cmd_type          cmd_data
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   logic    slot_valid_ff, slot_valid_in;
   cmd_type slot_ff, slot_in;
   logic    accept;

   // One holding slot: refill while the queue drains it.
   assign req_tready = !hold && (!slot_valid_ff || cmd_ready);
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = slot_valid_ff;
   assign cmd_data   = slot_ff;

   // Decode the transaction fields into a command.
   always_comb begin
      slot_in.action     = action_type'(req_tuser);
      slot_in.char_code  = req_tdata[7:0];
      slot_in.cell_index = req_tdata[18:8];
      slot_in.attr       = {req_tdata[22:19], req_tdata[26:23]};
      slot_in.last       = req_tlast;
      slot_in.is_newline = (req_tdata[7:0] == NEWLINE_CODE);
      slot_in.bad_index  = (32'(req_tdata[18:8]) >= 32'(CELLS));
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (accept) begin
         slot_valid_in = 1'b1;
      end else if (cmd_ready) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= slot_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEXT(a_accept_fills_slot, clock, reset, accept, slot_valid_ff, "accepted request lost")
   `ASSERT_IMPLIES(a_no_accept_on_hold, clock, reset, hold, !req_tready, "request taken while held")

endmodule

`default_nettype wire

// ===== hdl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front end and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  tcw_pkg::cmd_type  in_data,
   output logic              out_valid,
   input  wire               out_pop,
   output tcw_pkg::cmd_type  out_data
);
   import tcw_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_pop_not_empty, clock, reset, out_pop, out_valid, "pop from empty queue")

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executes console commands against the cell memory and issues results.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire [3:0]                 cfg_fg,
   input  wire [3:0]                 cfg_bg,
   input  wire                       cmd_valid,
   input  tcw_pkg::cmd_type          cmd_data,
   output logic                      cmd_pop,
   output logic                      init_busy,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output logic [tcw_pkg::RSP_W-1:0] rsp_tdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);

   // Cell memory: attribute in the upper byte, character in the lower.
   logic [15:0]    mem [CELLS];
   logic [15:0]    rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  cursor_ff, cursor_in;
   logic [AW-1:0]  row_base_ff, row_base_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [AW-1:0]  shown_ff, shown_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [AW:0]    src_ff, src_in;
   logic           pend_ff, pend_in;
   cmd_type        cur_ff, cur_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic           rsp_load;

   logic           out_free, take, put_scroll, sweep_last, last_copy, src_live;
   logic [15:0]    blank_cell;

   // Decisions shared by the state and datapath logic.
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      take       = (state_ff == ST_IDLE) && cmd_valid && out_free;
      sweep_last = (ptr_ff == AW'(CELLS - 1));
      last_copy  = pend_ff && (ptr_ff == AW'(CELLS - COLUMNS - 1));
      src_live   = (src_ff < (AW + 1)'(CELLS));
      blank_cell = {cfg_fg, cfg_bg, BLANK_CODE};
      if (cmd_data.is_newline) begin
         put_scroll = (row_base_ff == AW'(CELLS - COLUMNS));
      end else begin
         put_scroll = (cursor_ff == AW'(CELLS - 1));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               case (cmd_data.action)
                  ACT_PUT_CHAR:   state_in = put_scroll ? ST_SCROLL : ST_IDLE;
                  ACT_CLEAR:      state_in = ST_FILL;
                  ACT_READ_CELL:  state_in = cmd_data.bad_index ? ST_IDLE : ST_READ;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (last_copy) state_in = ST_BLANK_ROW;
         end
         ST_BLANK_ROW, ST_FILL: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory controls and result formation.
   always_comb begin
      cmd_pop      = take;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = blank_cell;
      mem_raddr    = src_ff[AW-1:0];
      cursor_in    = cursor_ff;
      row_base_in  = row_base_ff;
      col_in       = col_ff;
      shown_in     = shown_ff;
      ptr_in       = ptr_ff;
      src_in       = src_ff;
      pend_in      = 1'b0;
      cur_in       = cur_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_INIT: begin
            // Power-up blanking uses the register reset colors.
            mem_we    = 1'b1;
            mem_wdata = {FG_RESET, BG_RESET, BLANK_CODE};
            ptr_in    = sweep_last ? '0 : ptr_ff + AW'(1);
         end

         ST_IDLE: begin
            if (take) begin
               cur_in = cmd_data;
               case (cmd_data.action)
                  ACT_PUT_CHAR: begin
                     if (!cmd_data.is_newline) begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_ff;
                        mem_wdata = {cfg_fg, cfg_bg, cmd_data.char_code};
                     end
                     if (put_scroll) begin
                        // Park the cursor at the start of the bottom row.
                        cursor_in   = AW'(CELLS - COLUMNS);
                        row_base_in = AW'(CELLS - COLUMNS);
                        col_in      = '0;
                        ptr_in      = '0;
                        src_in      = (AW + 1)'(COLUMNS);
                     end else begin
                        if (cmd_data.is_newline || col_ff == CW'(COLUMNS - 1)) begin
                           row_base_in = row_base_ff + AW'(COLUMNS);
                           cursor_in   = row_base_ff + AW'(COLUMNS);
                           col_in      = '0;
                        end else begin
                           cursor_in = cursor_ff + AW'(1);
                           col_in    = col_ff + CW'(1);
                        end
                        shown_in     = cmd_data.last ? cursor_in : shown_ff;
                        rsp_load     = 1'b1;
                        rsp_data_in  = pack_rsp(11'(cursor_in), 11'(shown_in), 8'd0, 8'd0,
                                                1'b0, 1'b0);
                     end
                  end
                  ACT_WRITE_CELL: begin
                     mem_we      = !cmd_data.bad_index;
                     mem_waddr   = AW'(cmd_data.cell_index);
                     mem_wdata   = {cmd_data.attr, cmd_data.char_code};
                     rsp_load    = 1'b1;
                     rsp_data_in = pack_rsp(11'(cursor_ff), 11'(shown_ff), 8'd0, 8'd0,
                                            1'b0, cmd_data.bad_index);
                  end
                  ACT_CLEAR: begin
                     cursor_in   = '0;
                     row_base_in = '0;
                     col_in      = '0;
                     shown_in    = '0;
                     ptr_in      = '0;
                  end
                  ACT_READ_CELL: begin
                     mem_raddr = AW'(cmd_data.cell_index);
                     if (cmd_data.bad_index) begin
                        rsp_load    = 1'b1;
                        rsp_data_in = pack_rsp(11'(cursor_ff), 11'(shown_ff), 8'd0, 8'd0,
                                               1'b0, 1'b1);
                     end
                  end
                  default: begin
                     cur_in = cmd_data;
                  end
               endcase
            end
         end

         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_data_in = pack_rsp(11'(cursor_ff), 11'(shown_ff), rdata_ff[7:0],
                                   rdata_ff[15:8], 1'b0, 1'b0);
         end

         ST_SCROLL: begin
            // Read one row ahead, write the word read in the previous cycle.
            if (src_live) begin
               src_in  = src_ff + (AW + 1)'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = rdata_ff;
               ptr_in    = ptr_ff + AW'(1);
            end
         end

         ST_BLANK_ROW: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (sweep_last) begin
               ptr_in      = '0;
               shown_in    = cur_ff.last ? cursor_ff : shown_ff;
               rsp_load    = 1'b1;
               rsp_data_in = pack_rsp(11'(cursor_ff), 11'(shown_in), 8'd0, 8'd0,
                                      1'b1, 1'b0);
            end
         end

         ST_FILL: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (sweep_last) begin
               ptr_in      = '0;
               rsp_load    = 1'b1;
               rsp_data_in = pack_rsp(11'd0, 11'd0, 8'd0, 8'd0, 1'b0, 1'b0);
            end
         end

         default: begin
            mem_we = 1'b0;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cursor_ff    <= '0;
         row_base_ff  <= '0;
         col_ff       <= '0;
         shown_ff     <= '0;
         ptr_ff       <= '0;
         src_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         row_base_ff  <= row_base_in;
         col_ff       <= col_in;
         shown_ff     <= shown_in;
         ptr_ff       <= ptr_in;
         src_ff       <= src_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign init_busy  = (state_ff == ST_INIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_no_result_overwrite, clock, reset, rsp_load && rsp_valid_ff, rsp_tready, "pending result overwritten")
   `ASSERT_ALWAYS(a_cursor_in_screen, clock, reset, cursor_ff <= AW'(CELLS - 1), "cursor beyond screen")
   `ASSERT_ALWAYS(a_cursor_row_col, clock, reset, cursor_ff == row_base_ff + AW'(col_ff), "cursor row and column disagree")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. Console commands go in on
// the request stream and a mirror of the screen, the write cursor and the
// shown cursor predicts each response transaction. Each response is compared
// field by field. The run covers directed edge cases, scroll drills, random
// text lines, cell traffic and clears under several color settings and
// several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
   import tcw_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELLS         = COLUMNS * ROWS;
   localparam int MAX_INDEX     = 2047;
   localparam int PHASE_ITEMS   = 150;
   localparam int PHASES        = 5;
   // Quiet margin kept between phases before the color registers change.
   localparam int SETTLE_CYCLES = 2 * CELLS + 100;
   localparam int HOLD_CYCLES   = 400;

   // One console command as carried by a request transaction.
   typedef struct {
      action_type  action;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
      logic [3:0]  fg_in;
      logic [3:0]  bg_in;
      logic        last;
   } console_cmd_type;

   // Response layout, highest field first so the packed form matches rsp_tdata.
   typedef struct packed {
      logic        bad_index;
      logic        scrolled;
      logic [7:0]  read_attr;
      logic [7:0]  read_char;
      logic [10:0] shown_cursor;
      logic [10:0] cursor_pos;
   } console_status_type;

   // Screen mirror and response scoreboard.
   class console_scoreboard;
      logic [15:0]        screen [CELLS];
      int                 cursor;
      int                 shown;
      logic [3:0]         fg_color;
      logic [3:0]         bg_color;
      console_status_type due_status [$];
      int                 mismatches;
      int                 responses;

      function new();
         fg_color   = FG_RESET;
         bg_color   = BG_RESET;
         cursor     = 0;
         shown      = 0;
         mismatches = 0;
         responses  = 0;
         foreach (screen[k]) screen[k] = {FG_RESET, BG_RESET, BLANK_CODE};
      endfunction

      function void set_color(input logic addr, input logic [3:0] value);
         if (addr == CSR_DEFAULT_FG) fg_color = value;
         else bg_color = value;
      endfunction

      // Applies one accepted command to the mirror and queues its response.
      function void note_command(input console_cmd_type c);
         console_status_type s;
         logic [15:0]        blank;
         s     = '0;
         blank = {fg_color, bg_color, BLANK_CODE};
         case (c.action)
            ACT_PUT_CHAR: begin
               if (cursor >= CELLS) cursor = 0;
               if (c.char_code == NEWLINE_CODE) begin
                  cursor += COLUMNS - (cursor % COLUMNS);
               end else begin
                  screen[cursor] = {fg_color, bg_color, c.char_code};
                  cursor++;
               end
               // Running off the last cell moves every row up by one.
               if (cursor >= CELLS) begin
                  for (int k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
                  for (int k = CELLS - COLUMNS; k < CELLS; k++) screen[k] = blank;
                  cursor     = CELLS - COLUMNS;
                  s.scrolled = 1'b1;
               end
               if (c.last) shown = cursor;
            end
            ACT_WRITE_CELL: begin
               if (c.cell_index >= CELLS) s.bad_index = 1'b1;
               else screen[c.cell_index] = {c.fg_in, c.bg_in, c.char_code};
            end
            ACT_CLEAR: begin
               foreach (screen[k]) screen[k] = blank;
               cursor = 0;
               shown  = 0;
            end
            default: begin
               if (c.cell_index >= CELLS) begin
                  s.bad_index = 1'b1;
               end else begin
                  s.read_char = screen[c.cell_index][7:0];
                  s.read_attr = screen[c.cell_index][15:8];
               end
            end
         endcase
         s.cursor_pos   = 11'(cursor);
         s.shown_cursor = 11'(shown);
         due_status.push_back(s);
      endfunction

      task report_mismatch(input string what, input int got_v, input int want_v);
         mismatches++;
         $display("MISMATCH at response %0d: %s got %0d expected %0d",
                  responses, what, got_v, want_v);
      endtask

      task check_status(input logic [RSP_W-1:0] data);
         console_status_type got;
         console_status_type want;
         got = data;
         responses++;
         if (due_status.size() == 0) begin
            report_mismatch("response with nothing pending, cursor_pos", got.cursor_pos, -1);
         end else begin
            want = due_status.pop_front();
            if (got.cursor_pos != want.cursor_pos)
               report_mismatch("cursor_pos", got.cursor_pos, want.cursor_pos);
            if (got.shown_cursor != want.shown_cursor)
               report_mismatch("shown_cursor", got.shown_cursor, want.shown_cursor);
            if (got.read_char != want.read_char)
               report_mismatch("read_char", got.read_char, want.read_char);
            if (got.read_attr != want.read_attr)
               report_mismatch("read_attr", got.read_attr, want.read_attr);
            if (got.scrolled != want.scrolled)
               report_mismatch("scrolled", got.scrolled, want.scrolled);
            if (got.bad_index != want.bad_index)
               report_mismatch("bad_index", got.bad_index, want.bad_index);
         end
      endtask
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [1:0]       req_tuser  = ACT_PUT_CHAR;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we     = 1'b0;
   logic             csr_addr   = CSR_DEFAULT_FG;
   logic [3:0]       csr_wdata  = '0;

   console_scoreboard board = new();

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  phase_sent     = 0;
   int  phase          = 0;
   bit  hold_go        = 1'b0;
   bit  hold_done      = 1'b0;
   bit  pause_done     = 1'b0;
   int  hold_left      = 0;

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sink side: random stalls, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every response transaction is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_status(rsp_tdata);
   end

   function automatic console_cmd_type make_cmd(input action_type action, input logic [7:0] ch,
                                                input int idx, input logic [3:0] fg,
                                                input logic [3:0] bg, input logic last);
      console_cmd_type c;
      c.action     = action;
      c.char_code  = ch;
      c.cell_index = 11'(idx);
      c.fg_in      = fg;
      c.bg_in      = bg;
      c.last       = last;
      return c;
   endfunction

   // Every field random, including the ones the action ignores.
   function automatic console_cmd_type random_cmd();
      return make_cmd(action_type'($urandom_range(3)), 8'($urandom_range(255)),
                      $urandom_range(MAX_INDEX), 4'($urandom_range(15)),
                      4'($urandom_range(15)), 1'($urandom_range(1)));
   endfunction

   // Put-char with random payload; either a newline or a printable-or-not byte.
   function automatic console_cmd_type random_put(input bit newline, input logic last);
      console_cmd_type c;
      c        = random_cmd();
      c.action = ACT_PUT_CHAR;
      c.last   = last;
      if (newline) c.char_code = NEWLINE_CODE;
      else if (c.char_code == NEWLINE_CODE) c.char_code = BLANK_CODE;
      return c;
   endfunction

   // Mostly in range, a tenth beyond the screen.
   function automatic int random_index();
      if ($urandom_range(9) == 0) return $urandom_range(MAX_INDEX, CELLS);
      return $urandom_range(CELLS - 1);
   endfunction

   // Offers one request and returns once the transaction is accepted.
   task automatic send_command(input console_cmd_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.action;
      req_tlast  <= c.last;
      req_tdata  <= {5'd0, c.bg_in, c.fg_in, c.cell_index, c.char_code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_command(c);
      phase_sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (board.due_status.size() != 0);
   endtask

   // Writes both color registers on consecutive cycles.
   task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DEFAULT_FG;
      csr_wdata <= fg;
      @(negedge clock);
      csr_addr  <= CSR_DEFAULT_BG;
      csr_wdata <= bg;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_color(CSR_DEFAULT_FG, fg);
      board.set_color(CSR_DEFAULT_BG, bg);
   endtask

   // Edge cases under the reset colors.
   task automatic run_directed();
      send_command(make_cmd(ACT_READ_CELL, 8'h00, 0, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_READ_CELL, 8'hFF, CELLS - 1, 4'hF, 4'hF, 1'b1));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, CELLS, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, MAX_INDEX, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_WRITE_CELL, 8'hFF, MAX_INDEX, 4'hF, 4'hF, 1'b1));
      send_command(make_cmd(ACT_WRITE_CELL, 8'h55, CELLS, 4'h5, 4'hA, 1'b0));
      send_command(make_cmd(ACT_WRITE_CELL, 8'hFF, 0, 4'hF, 4'hF, 1'b0));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, 0, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_WRITE_CELL, 8'h00, CELLS - 1, 4'h0, 4'h0, 1'b1));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, CELLS - 1, 4'h0, 4'h0, 1'b0));
      // Text lands at the cursor; last_of_call copies it to the shown cursor.
      send_command(make_cmd(ACT_PUT_CHAR, 8'h41, 0, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_PUT_CHAR, 8'hFF, MAX_INDEX, 4'hF, 4'hF, 1'b1));
      send_command(make_cmd(ACT_PUT_CHAR, 8'h00, 0, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_PUT_CHAR, NEWLINE_CODE, 0, 4'h0, 4'h0, 1'b1));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, 1, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, 3, 4'h0, 4'h0, 1'b0));
      // A newline at a row start still moves a whole row.
      send_command(make_cmd(ACT_PUT_CHAR, NEWLINE_CODE, 0, 4'h0, 4'h0, 1'b0));
      // Clear ignores last_of_call and resets both cursors.
      send_command(make_cmd(ACT_CLEAR, 8'hFF, MAX_INDEX, 4'hF, 4'hF, 1'b1));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, 0, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, CELLS - 1, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_PUT_CHAR, 8'h7E, 0, 4'h0, 4'h0, 1'b0));
      // Cell access with last_of_call set leaves the shown cursor alone.
      send_command(make_cmd(ACT_WRITE_CELL, 8'h33, 5, 4'h3, 4'hC, 1'b1));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, 5, 4'h0, 4'h0, 1'b1));
   endtask

   // Walks the cursor to the bottom row and forces one scroll, either by a
   // newline there or by running text off the last cell.
   task automatic scroll_drill(input bit by_wrap);
      int count;
      while (board.cursor < CELLS - COLUMNS) send_command(random_put(1'b1, 1'b0));
      if (by_wrap) begin
         count = CELLS - board.cursor;
         for (int k = 0; k < count; k++) send_command(random_put(1'b0, k == count - 1));
      end else begin
         send_command(random_put(1'b1, 1'b1));
      end
      send_command(make_cmd(ACT_READ_CELL, 8'h00, CELLS - COLUMNS, 4'h0, 4'h0, 1'b0));
      send_command(make_cmd(ACT_READ_CELL, 8'h00, CELLS - 2 * COLUMNS, 4'h0, 4'h0, 1'b0));
   endtask

   // One burst of random traffic, mostly well-formed text lines.
   task automatic run_random_burst();
      console_cmd_type c;
      int              pick;
      int              len;
      pick = $urandom_range(99);
      if (phase == 4 && phase_sent >= 40) hold_go = 1'b1;
      if (phase == 2 && phase_sent >= 60 && !pause_done) begin
         wait_drained();
         pause_done = 1'b1;
      end
      if (pick < 55) begin
         // A write call: a run of characters, often closed by a newline.
         len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(16, 1);
         for (int k = 0; k < len - 1; k++) send_command(random_put(1'b0, 1'b0));
         send_command(random_put($urandom_range(3) != 0, 1'b1));
      end else if (pick < 75) begin
         c = random_cmd();
         c.action = ACT_WRITE_CELL;
         c.cell_index = 11'(random_index());
         send_command(c);
         if ($urandom_range(1)) begin
            c = random_cmd();
            c.action = ACT_READ_CELL;
            send_command(c);
         end
      end else if (pick < 93) begin
         c = random_cmd();
         c.action = ACT_READ_CELL;
         if ($urandom_range(2) == 0) c.cell_index = 11'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
         else c.cell_index = 11'(random_index());
         send_command(c);
      end else if (pick < 95) begin
         c = random_cmd();
         c.action = ACT_CLEAR;
         send_command(c);
      end else begin
         send_command(random_cmd());
      end
   endtask

   // Main sequence: reset, then the phases, then the final verdict.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clock);
            case (phase)
               1:       write_colors(4'h0, 4'h0);
               2:       write_colors(4'hF, 4'hF);
               3:       write_colors(4'h0, 4'hF);
               default: write_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
            endcase
         end
         case (phase)
            1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
            3:       begin send_idle_pct = 21; recv_stall_pct = 21; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         phase_sent = 0;
         if (phase == 0) run_directed();
         else scroll_drill(phase == 2);
         while (phase_sent < PHASE_ITEMS) run_random_burst();
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // Watchdog for a hung handshake; well above a run in which every
   // command walks the whole store.
   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
